/* hdl/text_console_cursor_engine_defines.svh */
// Assertion macros for the text console cursor engine.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCCE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tcce_pkg.sv */
// Package for the text console cursor engine: screen geometry, field widths,
// character and function codes. Has no dependencies.
`default_nettype none

package tcce_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CELL_W = $clog2(CELLS);

   localparam int FUNC_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int RIDX_W      = 11;
   localparam int POS_W       = 11;
   localparam int COLOR_W     = 8;
   localparam int CELL_DATA_W = 16;

   localparam int REQ_TDATA_W = ((CHAR_W + RIDX_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((CHAR_W + POS_W + CELL_DATA_W + 7) / 8) * 8;

   localparam logic [ROW_W:0] ROW_END = (ROW_W + 1)'(ROWS);
   localparam logic [COL_W:0] COL_END = (COL_W + 1)'(COLUMNS);
   localparam logic [COL_W:0] TAB_STEP = (COL_W + 1)'(8);

   localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

   localparam logic [COLOR_W-1:0]     COLOR_RESET = 8'h0B;
   localparam logic [CELL_DATA_W-1:0] BLANK_INIT  = {COLOR_RESET, CHAR_SPACE};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT,
      FUNC_BACKSPACE,
      FUNC_CLEAR,
      FUNC_READ
   } func_type;

   typedef enum logic [1:0] {
      ECHO_NONE,
      ECHO_ONE,
      ECHO_NEWLINE,
      ECHO_BACKSPACE
   } echo_type;

endpackage

`default_nettype wire

/* hdl/tcce_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the cell store of the text console cursor engine; no dependencies.
`default_nettype none

module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/text_console_cursor_engine.sv */
// Text console cursor engine: a ROWS by COLUMNS cell store with a cursor, driven by
// put, backspace, clear and read items, emitting echo bytes and the cursor position.
// Depends on tcce_pkg, tcce_ram and text_console_cursor_engine_defines.svh.
//
// After reset the block sweeps the cell store once, one cell per cycle, writing blank
// cells with color 0x0B; no item is taken meanwhile, though color writes are. An item
// is taken in S_IDLE and its results then leave one per cycle through the output
// register while the output is not stalled; a read first passes through S_READ for
// the store read. A scroll walks the store, copying each cell up one row, one cell per
// cycle, and then blanks the bottom row; a clear blanks every cell, one cell per cycle.
`default_nettype none

`include "text_console_cursor_engine_defines.svh"

module text_console_cursor_engine (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [tcce_pkg::COLOR_W-1:0]        csr_wr_data,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0: char_code, read_index.
   input  wire logic [tcce_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // Fields from bit 0: func.
   input  wire logic [tcce_pkg::FUNC_W-1:0]         req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // Fields from bit 0: serial_byte, cursor_pos, cell_value.
   output logic [tcce_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   // Fields from bit 0: serial_valid.
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_SCROLL,
      S_BLANK,
      S_EMIT
   } state_type;

   state_type                              state_ff, state_in;
   logic [tcce_pkg::ROW_W-1:0]             row_ff, row_in;
   logic [tcce_pkg::COL_W-1:0]             col_ff, col_in;
   logic [tcce_pkg::CELL_W-1:0]            sw_ff, sw_in;
   logic                                   wb_valid_ff, wb_valid_in;
   logic [tcce_pkg::CELL_W-1:0]            wb_addr_ff, wb_addr_in;
   tcce_pkg::echo_type                     echo_kind_ff, echo_kind_in;
   logic [tcce_pkg::CHAR_W-1:0]            echo_byte_ff, echo_byte_in;
   logic [1:0]                             emit_idx_ff, emit_idx_in;
   logic [1:0]                             emit_last_ff, emit_last_in;
   logic                                   rd_ok_ff, rd_ok_in;
   logic [tcce_pkg::CELL_DATA_W-1:0]       cell_ff, cell_in;
   logic [tcce_pkg::COLOR_W-1:0]           color_ff, color_in;
   logic                                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [tcce_pkg::RSP_TDATA_W-1:0]       rsp_tdata_ff, rsp_tdata_in;
   logic                                   rsp_tuser_ff, rsp_tuser_in;
   logic                                   rsp_tlast_ff, rsp_tlast_in;

   logic                                   ram_wr_en;
   logic [tcce_pkg::CELL_W-1:0]            ram_wr_addr;
   logic [tcce_pkg::CELL_DATA_W-1:0]       ram_wr_data;
   logic [tcce_pkg::CELL_W-1:0]            ram_rd_addr;
   logic [tcce_pkg::CELL_DATA_W-1:0]       ram_rd_data;

   tcce_pkg::func_type                     fn;
   logic [tcce_pkg::CHAR_W-1:0]            ch;
   logic [tcce_pkg::RIDX_W-1:0]            ridx;
   logic [tcce_pkg::CELL_W-1:0]            cur_idx;
   logic [tcce_pkg::ROW_W:0]               row_ext;
   logic [tcce_pkg::COL_W:0]               col_ext;
   logic [tcce_pkg::COL_W:0]               col_inc;
   logic [tcce_pkg::COL_W:0]               tab_col;
   logic [tcce_pkg::CELL_DATA_W-1:0]       blank_cell;
   logic                                   adv;
   logic                                   echo_valid;
   logic [tcce_pkg::CHAR_W-1:0]            echo_byte;

   tcce_ram #(
      .WIDTH (tcce_pkg::CELL_DATA_W),
      .DEPTH (tcce_pkg::CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign fn   = tcce_pkg::func_type'(req_tuser);
   assign ch   = req_tdata[tcce_pkg::CHAR_W-1:0];
   assign ridx = req_tdata[tcce_pkg::CHAR_W +: tcce_pkg::RIDX_W];

   assign cur_idx = tcce_pkg::CELL_W'(row_ff) * tcce_pkg::CELL_W'(tcce_pkg::COLUMNS)
                    + tcce_pkg::CELL_W'(col_ff);
   assign row_ext = {1'b0, row_ff};
   assign col_ext = {1'b0, col_ff};
   assign col_inc = col_ext + 1'b1;
   assign tab_col = (col_ext + tcce_pkg::TAB_STEP) & ~(tcce_pkg::TAB_STEP - 1'b1);
   assign blank_cell = {color_ff, tcce_pkg::CHAR_SPACE};

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   always_comb begin
      echo_valid = 1'b1;
      echo_byte  = '0;
      case (echo_kind_ff)
         tcce_pkg::ECHO_ONE: begin
            echo_byte = echo_byte_ff;
         end
         tcce_pkg::ECHO_NEWLINE: begin
            echo_byte = (emit_idx_ff == 2'd0) ? tcce_pkg::CHAR_CR : tcce_pkg::CHAR_NL;
         end
         tcce_pkg::ECHO_BACKSPACE: begin
            echo_byte = (emit_idx_ff == 2'd1) ? tcce_pkg::CHAR_SPACE : tcce_pkg::CHAR_BS;
         end
         default: begin
            echo_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      sw_in         = sw_ff;
      wb_valid_in   = 1'b0;
      wb_addr_in    = wb_addr_ff;
      echo_kind_in  = echo_kind_ff;
      echo_byte_in  = echo_byte_ff;
      emit_idx_in   = emit_idx_ff;
      emit_last_in  = emit_last_ff;
      rd_ok_in      = rd_ok_ff;
      cell_in       = cell_ff;
      color_in      = csr_wr_en ? csr_wr_data : color_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      ram_wr_en     = wb_valid_ff;
      ram_wr_addr   = wb_addr_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = '0;
      adv           = 1'b0;

      case (state_ff)
         S_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sw_ff;
            ram_wr_data = tcce_pkg::BLANK_INIT;
            if (sw_ff == tcce_pkg::CELL_W'(tcce_pkg::CELLS - 1)) begin
               state_in = S_IDLE;
            end else begin
               sw_in = sw_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               state_in     = S_EMIT;
               echo_kind_in = tcce_pkg::ECHO_ONE;
               echo_byte_in = ch;
               emit_idx_in  = 2'd0;
               emit_last_in = 2'd0;
               cell_in      = '0;
               case (fn)
                  tcce_pkg::FUNC_PUT: begin
                     if (ch == tcce_pkg::CHAR_NL) begin
                        echo_kind_in = tcce_pkg::ECHO_NEWLINE;
                        emit_last_in = 2'd1;
                        col_in       = '0;
                        adv          = 1'b1;
                     end else if (ch == tcce_pkg::CHAR_CR) begin
                        col_in = '0;
                     end else if (ch == tcce_pkg::CHAR_TAB) begin
                        if (tab_col >= tcce_pkg::COL_END) begin
                           col_in = '0;
                           adv    = 1'b1;
                        end else begin
                           col_in = tab_col[tcce_pkg::COL_W-1:0];
                        end
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cur_idx;
                        ram_wr_data = {color_ff, ch};
                        if (col_inc >= tcce_pkg::COL_END) begin
                           col_in = '0;
                           adv    = 1'b1;
                        end else begin
                           col_in = col_inc[tcce_pkg::COL_W-1:0];
                        end
                     end
                  end
                  tcce_pkg::FUNC_BACKSPACE: begin
                     echo_kind_in = tcce_pkg::ECHO_BACKSPACE;
                     emit_last_in = 2'd2;
                     if (cur_idx != '0) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cur_idx - 1'b1;
                        ram_wr_data = blank_cell;
                        if (col_ff != '0) begin
                           col_in = col_ff - 1'b1;
                        end else begin
                           row_in = row_ff - 1'b1;
                           col_in = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
                        end
                     end
                  end
                  tcce_pkg::FUNC_CLEAR: begin
                     echo_kind_in = tcce_pkg::ECHO_NONE;
                     row_in       = '0;
                     col_in       = '0;
                     sw_in        = '0;
                     state_in     = S_BLANK;
                  end
                  default: begin
                     echo_kind_in = tcce_pkg::ECHO_NONE;
                     ram_rd_addr  = tcce_pkg::CELL_W'(ridx);
                     rd_ok_in     = (32'(ridx) < tcce_pkg::CELLS);
                     state_in     = S_READ;
                  end
               endcase
               if (adv) begin
                  if (row_ext + 1'b1 >= tcce_pkg::ROW_END) begin
                     sw_in    = '0;
                     state_in = S_SCROLL;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
            end
         end
         S_READ: begin
            cell_in  = rd_ok_ff ? ram_rd_data : '0;
            state_in = S_EMIT;
         end
         S_SCROLL: begin
            ram_rd_addr = sw_ff + tcce_pkg::CELL_W'(tcce_pkg::COLUMNS);
            wb_valid_in = 1'b1;
            wb_addr_in  = sw_ff;
            if (sw_ff == tcce_pkg::CELL_W'(tcce_pkg::CELLS - tcce_pkg::COLUMNS - 1)) begin
               sw_in    = tcce_pkg::CELL_W'(tcce_pkg::CELLS - tcce_pkg::COLUMNS);
               state_in = S_BLANK;
            end else begin
               sw_in = sw_ff + 1'b1;
            end
         end
         S_BLANK: begin
            if (!wb_valid_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = sw_ff;
               ram_wr_data = blank_cell;
               if (sw_ff == tcce_pkg::CELL_W'(tcce_pkg::CELLS - 1)) begin
                  state_in = S_EMIT;
               end else begin
                  sw_in = sw_ff + 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = echo_valid;
               rsp_tlast_in  = (emit_idx_ff == emit_last_ff);
               rsp_tdata_in  = tcce_pkg::RSP_TDATA_W'({cell_ff,
                                                      tcce_pkg::POS_W'(cur_idx),
                                                      echo_byte});
               if (emit_idx_ff == emit_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         row_ff        <= '0;
         col_ff        <= '0;
         sw_ff         <= '0;
         wb_valid_ff   <= 1'b0;
         emit_idx_ff   <= '0;
         emit_last_ff  <= '0;
         color_ff      <= tcce_pkg::COLOR_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         sw_ff         <= sw_in;
         wb_valid_ff   <= wb_valid_in;
         emit_idx_ff   <= emit_idx_in;
         emit_last_ff  <= emit_last_in;
         color_ff      <= color_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      wb_addr_ff   <= wb_addr_in;
      echo_kind_ff <= echo_kind_in;
      echo_byte_ff <= echo_byte_in;
      rd_ok_ff     <= rd_ok_in;
      cell_ff      <= cell_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   `TCCE_ASSERT_NOW(a_cursor_on_screen, state_ff == S_IDLE, (row_ext < tcce_pkg::ROW_END) && (col_ext < tcce_pkg::COL_END), "cursor outside the screen while idle")
   `TCCE_ASSERT_NOW(a_writeback_in_scroll, wb_valid_ff, (state_ff == S_SCROLL) || (state_ff == S_BLANK), "scroll write-back pending outside a scroll")
   `TCCE_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready held high right after an item was taken")
   `TCCE_ASSERT_NOW(a_emit_index, state_ff == S_EMIT, emit_idx_ff <= emit_last_ff, "result index past the last result of the item")

endmodule

`default_nettype wire
